// ===== hw/rtl/htfc_pkg.sv =====
// shared types, constants and crc helper for the humidity/temperature frame converter
// no dependencies
`default_nettype none

package htfc_pkg;

  localparam int CrcW    = 8;
  localparam int DataW   = 8;
  localparam int CmdW    = 2;
  localparam int RawW    = 16;
  localparam int ValueW  = 17;
  localparam int ProdW   = 31;
  localparam int DiffW   = 32;
  localparam int MagHiW  = 14;
  localparam int QuotW   = 11;
  localparam int RecipW  = 16;

  localparam logic [CrcW-1:0] CrcPoly = 8'h31;
  localparam logic [CrcW-1:0] CrcInit = 8'h00;

  // command codes
  localparam logic [CmdW-1:0] CmdTemp  = 2'd0;
  localparam logic [CmdW-1:0] CmdHumid = 2'd1;

  // scaling constants: hundredths of a unit for temperature, tenths for humidity
  localparam logic [14:0]      TempCoef    = 15'd17572;
  localparam logic [14:0]      HumidCoef   = 15'd1250;
  localparam logic [DiffW-1:0] TempOffset  = 32'd307036160; // 4685 * 65536
  localparam logic [DiffW-1:0] HumidOffset = 32'd3932160;   // 60 * 65536
  // floor(x / 10) = (x * 52429) >> 19, exact for x below 2^18
  localparam logic [RecipW-1:0] RecipTen   = 16'd52429;
  localparam int               RecipShift  = 19;

  typedef enum logic [1:0] {
    KIND_TEMP,
    KIND_HUMID,
    KIND_RAW
  } kind_t;

  typedef struct packed {
    logic             crc_err;
    kind_t            kind;
    logic [RawW-1:0]  raw;
  } frame_info_t;

  function automatic logic [CrcW-1:0] crc8_byte(input logic [CrcW-1:0] crc_in,
                                                input logic [DataW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/humidity_temperature_frame_convert_core.sv =====
// top level of the humidity/temperature frame converter: four register stages
// depends on htfc_pkg and htfc_crc_check
`default_nettype none

// One sensor reply frame is taken per clock: a request is accepted whenever start is
// high, since busy is always low. The result appears on the out_ ports for one cycle,
// marked by out_valid; the receiver cannot stall it. Latency is set by the input
// register, the scaling multiplier, the magnitude/shift stage and the divide-by-ten
// reciprocal multiplier, each followed by a register. A crc mismatch gives
// out_crc_error high and out_value zero.
module humidity_temperature_frame_convert_core
  import htfc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [CmdW-1:0]          in_command,
  input  wire logic [DataW-1:0]         in_data_high,
  input  wire logic [DataW-1:0]         in_data_low,
  input  wire logic [CrcW-1:0]          in_checksum,
  output logic                          out_valid,
  output logic signed [ValueW-1:0]      out_value,
  output logic                          out_crc_error
);

  // ---------------------------------------------------------------------------
  // stage 0: input register
  // ---------------------------------------------------------------------------
  logic              v0_r;
  logic [CmdW-1:0]   cmd0_r;
  logic [DataW-1:0]  hi0_r;
  logic [DataW-1:0]  lo0_r;
  logic [CrcW-1:0]   chk0_r;

  // never stalls, a new request every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    cmd0_r <= in_command;
    hi0_r  <= in_data_high;
    lo0_r  <= in_data_low;
    chk0_r <= in_checksum;
  end

  // ---------------------------------------------------------------------------
  // stage 1: crc check, command decode, scale multiply
  // ---------------------------------------------------------------------------
  logic           crc_err0;
  frame_info_t    info1_nxt;
  logic [14:0]    coef;
  logic [ProdW-1:0] prod1_nxt;

  htfc_crc_check u_crc (
    .data_high (hi0_r),
    .data_low  (lo0_r),
    .checksum  (chk0_r),
    .crc_error (crc_err0)
  );

  always_comb begin
    info1_nxt.crc_err = crc_err0;
    info1_nxt.raw     = {hi0_r, lo0_r};
    case (cmd0_r)
      CmdTemp:  info1_nxt.kind = KIND_TEMP;
      CmdHumid: info1_nxt.kind = KIND_HUMID;
      default:  info1_nxt.kind = KIND_RAW;    // unused code falls back to raw
    endcase
    // one shared multiplier, coefficient picked by kind
    coef      = (info1_nxt.kind == KIND_TEMP) ? TempCoef : HumidCoef;
    prod1_nxt = ProdW'(info1_nxt.raw) * ProdW'(coef);
  end

  logic             v1_r;
  frame_info_t      info1_r;
  logic [ProdW-1:0] prod1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    info1_r <= info1_nxt;
    prod1_r <= prod1_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage 2: subtract offset, take magnitude, drop the 2^16 factor
  // truncation toward zero is done on the magnitude, sign put back later
  // ---------------------------------------------------------------------------
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        mag;
  logic                    neg2_nxt;
  logic [MagHiW-1:0]       x2_nxt;

  always_comb begin
    diff = signed'({1'b0, prod1_r})
         - signed'((info1_r.kind == KIND_TEMP) ? TempOffset : HumidOffset);
    neg2_nxt = diff[DiffW-1];
    mag      = neg2_nxt ? DiffW'(-diff) : DiffW'(diff);
    // magnitude stays below 2^30
    x2_nxt   = mag[16 +: MagHiW];
  end

  logic              v2_r;
  frame_info_t       info2_r;
  logic              neg2_r;
  logic [MagHiW-1:0] x2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    info2_r <= info1_r;
    neg2_r  <= neg2_nxt;
    x2_r    <= x2_nxt;
  end

  // ---------------------------------------------------------------------------
  // stage 3: divide by ten for temperature, sign, error and kind select
  // ---------------------------------------------------------------------------
  logic [MagHiW+RecipW-1:0]  recip_prod;
  logic [QuotW-1:0]          quot;
  logic signed [ValueW-1:0]  mag_val;
  logic signed [ValueW-1:0]  value_nxt;

  always_comb begin
    recip_prod = (MagHiW+RecipW)'(x2_r) * (MagHiW+RecipW)'(RecipTen);
    if (info2_r.kind == KIND_TEMP) begin
      quot = recip_prod[RecipShift +: QuotW];
    end else begin
      quot = x2_r[QuotW-1:0];
    end
    mag_val = signed'(ValueW'(quot));
    if (info2_r.crc_err) begin
      value_nxt = '0;
    end else if (info2_r.kind == KIND_RAW) begin
      value_nxt = signed'(ValueW'(info2_r.raw));
    end else begin
      value_nxt = neg2_r ? -mag_val : mag_val;
    end
  end

  logic                     out_valid_r;
  logic signed [ValueW-1:0] out_value_r;
  logic                     out_crc_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r     <= value_nxt;
    out_crc_error_r <= info2_r.crc_err;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_crc_error = out_crc_error_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // every accepted request is followed by a result strobe on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("request did not produce a result after four cycles");

  // no result without a matching earlier request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result strobe without a matching request");

  // a failed check always reports zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_crc_error) |-> (out_value == '0))
    else $error("crc error with nonzero value");

  // results never fall below the converted range
  a_value_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value >= -17'sd469))
    else $error("value below the converted range");

endmodule

`default_nettype wire

// ===== hw/rtl/htfc_crc_check.sv =====
// crc-8 check over the two data bytes against the received checksum
// depends on htfc_pkg
`default_nettype none

module htfc_crc_check
  import htfc_pkg::*;
(
  input  wire logic [DataW-1:0] data_high,
  input  wire logic [DataW-1:0] data_low,
  input  wire logic [CrcW-1:0]  checksum,
  output logic                  crc_error
);

  logic [CrcW-1:0] crc_hi;
  logic [CrcW-1:0] crc_full;

  // high byte first
  assign crc_hi    = crc8_byte(CrcInit, data_high);
  assign crc_full  = crc8_byte(crc_hi, data_low);
  assign crc_error = (crc_full != checksum);

endmodule

`default_nettype wire
